@@ rtl/multi_button_long_press_detector_unit_defines.svh @@
// Assertion macros for the detector unit, which checks its own logic.
`ifndef MULTI_BUTTON_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define MULTI_BUTTON_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBLP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBLP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mblp_pkg.sv @@
package mblp_pkg;

    localparam int BUTTON_COUNT = 6;
    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int BTN_W = 3;
    localparam int CNT_W = 16;
    localparam int MASK_W = 6;
    localparam int KIND_W = 2;
    localparam int CODE_W = 2;

    localparam logic [CNT_W-1:0] TICKS_RESET = 16'd3000;
    localparam logic [MASK_W-1:0] MASK_RESET = 6'd3;

    localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [CODE_W-1:0] EV_PRESS = 2'd0;
    localparam logic [CODE_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [CODE_W-1:0] EV_LONG_PRESS = 2'd2;
    localparam logic [CODE_W-1:0] EV_LONG_RELEASE = 2'd3;

    localparam logic CFG_TICKS = 1'b0;
    localparam logic CFG_MASK = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic [CNT_W-1:0] cd;
    } entry_t;

    typedef struct packed {
        logic en;
        logic [IDX_W-1:0] idx;
        entry_t entry;
    } entry_wr_t;

endpackage

@@ rtl/mblp_dec_unit.sv @@
module mblp_dec_unit (
    input  logic [mblp_pkg::CNT_W-1:0] value,
    output logic [mblp_pkg::CNT_W-1:0] dec_value,
    output logic                       expires
);

    assign dec_value = value - mblp_pkg::CNT_W'(1);
    assign expires = (value == mblp_pkg::CNT_W'(1));

endmodule

@@ rtl/mblp_btn_file.sv @@
module mblp_btn_file (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mblp_pkg::IDX_W-1:0] rd_idx,
    output mblp_pkg::entry_t           rd_entry,
    input  mblp_pkg::entry_wr_t        wr
);

    mblp_pkg::entry_t entry_reg [mblp_pkg::BUTTON_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mblp_pkg::BUTTON_COUNT; i++) begin
                entry_reg[i].phase <= mblp_pkg::PH_IDLE;
                entry_reg[i].cd <= '0;
            end
        end else if (wr.en) begin
            entry_reg[wr.idx] <= wr.entry;
        end
    end

    assign rd_entry = entry_reg[rd_idx];

endmodule

@@ rtl/multi_button_long_press_detector_unit.sv @@
// Multi-button long-press detector.
// Input items arrive on the s_ stream: a level change, a cancel or one time tick.
// Each level change or cancel for a valid button is handled in the update step after
// acceptance; a tick walks the button entries one per cycle while the output register
// is free, through a shared countdown decrement unit, and then passes a flush step.
// s_tready is high only while the sequencer is idle.
// Events leave on the m_ stream from an output register, one transaction per event;
// m_tlast marks the last event caused by one input item. An item that causes no event
// produces no output transaction. While the receiver stalls with the output register
// full, the sequencer holds at its current update, scan or flush step, whether or not
// that step emits an event, and the next item may be accepted while the final event
// of the previous one still waits in the output register.
// Configuration writes (index 0 long-press ticks, index 1 long-press mask) take effect
// at the clock edge where cfg_we is high.
// Reset (aresetn low, synchronous) returns all buttons to idle with zero countdowns,
// clears the output register and restores the register defaults.
`include "multi_button_long_press_detector_unit_defines.svh"

module multi_button_long_press_detector_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // kind[1:0], button[4:2], level[5], zero
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // event_button[2:0], event_code[4:3], zero
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mblp_pkg::CNT_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic [mblp_pkg::CNT_W-1:0] ticks_reg, ticks_next;
    logic [mblp_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [mblp_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic level_reg, level_next;
    logic [mblp_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic pend_valid_reg, pend_valid_next;
    logic [mblp_pkg::IDX_W-1:0] pend_btn_reg, pend_btn_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [mblp_pkg::BTN_W-1:0] m_btn_reg, m_btn_next;
    logic [mblp_pkg::CODE_W-1:0] m_code_reg, m_code_next;
    logic m_last_reg, m_last_next;

    mblp_pkg::entry_t rd_entry;
    mblp_pkg::entry_wr_t wr;
    logic [mblp_pkg::CNT_W-1:0] dec_value;
    logic expires;

    logic [mblp_pkg::KIND_W-1:0] in_kind;
    logic [mblp_pkg::BTN_W-1:0] in_button;
    logic in_level;
    logic out_free;
    logic uses_long;
    logic [mblp_pkg::CNT_W-1:0] load_value;

    assign in_kind = s_tdata[1:0];
    assign in_button = s_tdata[4:2];
    assign in_level = s_tdata[5];

    mblp_btn_file u_btn_file (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    mblp_dec_unit u_dec (
        .value     (rd_entry.cd),
        .dec_value (dec_value),
        .expires   (expires)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign load_value = (ticks_reg == '0) ? mblp_pkg::CNT_W'(1) : ticks_reg;

    always_comb begin
        uses_long = 1'b0;
        for (int i = 0; i < mblp_pkg::MASK_W; i++) begin
            if (i < mblp_pkg::BUTTON_COUNT && idx_reg == mblp_pkg::IDX_W'(i)) begin
                uses_long = mask_reg[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ticks_next = ticks_reg;
        mask_next = mask_reg;
        kind_next = kind_reg;
        level_next = level_reg;
        idx_next = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_btn_next = pend_btn_reg;
        m_tvalid_next = m_tvalid_reg;
        m_btn_next = m_btn_reg;
        m_code_next = m_code_reg;
        m_last_next = m_last_reg;
        wr.en = 1'b0;
        wr.idx = idx_reg;
        wr.entry = rd_entry;

        if (cfg_we) begin
            if (cfg_index == mblp_pkg::CFG_TICKS) begin
                ticks_next = cfg_data;
            end else begin
                mask_next = cfg_data[mblp_pkg::MASK_W-1:0];
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next = in_kind;
                    level_next = in_level;
                    if (in_kind == mblp_pkg::KIND_TICK) begin
                        idx_next = '0;
                        state_next = ST_SCAN;
                    end else if ((in_kind == mblp_pkg::KIND_LEVEL ||
                                  in_kind == mblp_pkg::KIND_CANCEL) &&
                                 32'(in_button) < mblp_pkg::BUTTON_COUNT) begin
                        idx_next = mblp_pkg::IDX_W'(in_button);
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    m_btn_next = mblp_pkg::BTN_W'(idx_reg);
                    m_last_next = 1'b1;
                    if (kind_reg == mblp_pkg::KIND_CANCEL) begin
                        if (rd_entry.phase == mblp_pkg::PH_PRESSED ||
                            rd_entry.phase == mblp_pkg::PH_LONG) begin
                            wr.en = 1'b1;
                            wr.entry.phase = mblp_pkg::PH_IDLE;
                            wr.entry.cd = '0;
                        end
                    end else if (!level_reg) begin
                        if (rd_entry.phase == mblp_pkg::PH_IDLE) begin
                            wr.en = 1'b1;
                            wr.entry.phase = mblp_pkg::PH_PRESSED;
                            if (uses_long) begin
                                wr.entry.cd = load_value;
                            end else begin
                                m_tvalid_next = 1'b1;
                                m_code_next = mblp_pkg::EV_PRESS;
                            end
                        end
                    end else begin
                        if (rd_entry.phase == mblp_pkg::PH_PRESSED ||
                            rd_entry.phase == mblp_pkg::PH_LONG) begin
                            wr.en = 1'b1;
                            wr.entry.phase = mblp_pkg::PH_IDLE;
                            wr.entry.cd = '0;
                            m_tvalid_next = 1'b1;
                            m_code_next = (rd_entry.phase == mblp_pkg::PH_PRESSED) ?
                                          mblp_pkg::EV_RELEASE : mblp_pkg::EV_LONG_RELEASE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (rd_entry.phase == mblp_pkg::PH_PRESSED && rd_entry.cd != '0) begin
                        wr.en = 1'b1;
                        wr.entry.cd = dec_value;
                        if (expires) begin
                            wr.entry.phase = mblp_pkg::PH_LONG;
                            if (pend_valid_reg) begin
                                m_tvalid_next = 1'b1;
                                m_btn_next = mblp_pkg::BTN_W'(pend_btn_reg);
                                m_code_next = mblp_pkg::EV_LONG_PRESS;
                                m_last_next = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_btn_next = idx_reg;
                        end
                    end
                    if (32'(idx_reg) == mblp_pkg::BUTTON_COUNT - 1) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + mblp_pkg::IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_btn_next = mblp_pkg::BTN_W'(pend_btn_reg);
                        m_code_next = mblp_pkg::EV_LONG_PRESS;
                        m_last_next = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ticks_reg <= mblp_pkg::TICKS_RESET;
            mask_reg <= mblp_pkg::MASK_RESET;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
            mask_reg <= mask_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        kind_reg <= kind_next;
        level_reg <= level_next;
        idx_reg <= idx_next;
        pend_btn_reg <= pend_btn_next;
        m_btn_reg <= m_btn_next;
        m_code_reg <= m_code_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {3'b000, m_code_reg, m_btn_reg};
    assign m_tlast = m_last_reg;

    `MBLP_ASSERT_SAME(a_ready_no_pending, aclk, aresetn, s_tready, !pend_valid_reg,
        "input accepted while a long-press event is still pending")
    `MBLP_ASSERT_SAME(a_pending_in_scan, aclk, aresetn, pend_valid_reg,
        (state_reg == ST_SCAN || state_reg == ST_FLUSH),
        "pending long-press event outside of a tick scan")
    `MBLP_ASSERT_SAME(a_scan_index, aclk, aresetn, state_reg == ST_SCAN,
        32'(idx_reg) < mblp_pkg::BUTTON_COUNT, "scan index beyond the button count")
    `MBLP_ASSERT_NEXT(a_flush_done, aclk, aresetn,
        (state_reg == ST_FLUSH && out_free), state_reg == ST_IDLE,
        "flush did not return the sequencer to idle")

endmodule

@@ bench/multi_button_long_press_detector_unit_tb.sv @@
module multi_button_long_press_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mblp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [BTN_W-1:0]  button;
        logic [CODE_W-1:0] code;
        logic              last;
    } event_t;

    typedef struct packed {
        logic              cfg;
        logic [CNT_W-1:0]  ticks;
        logic [MASK_W-1:0] mask;
        logic [KIND_W-1:0] kind;
        logic [BTN_W-1:0]  btn;
        logic              lvl;
        logic              typed;
        logic              has_ev;
        logic [BTN_W-1:0]  ev_btn;
        logic [CODE_W-1:0] ev_code;
    } dir_row_t;

    // Columns: write config first, ticks, mask, kind, button, level,
    // expectation typed in, typed event present, typed button, typed code.
    localparam dir_row_t DIRECTED [25] = '{
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd2, 1'b0, 1'b1, 1'b1, 3'd2, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd2, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd2, 1'b1, 1'b1, 1'b1, 3'd2, EV_RELEASE},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd2, 1'b1, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd0, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd0, 1'b1, 1'b1, 1'b1, 3'd0, EV_RELEASE},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd6, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_CANCEL, 3'd7, 1'b1, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_UNUSED, 3'd5, 1'b1, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_CANCEL, 3'd3, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd5, 1'b0, 1'b1, 1'b1, 3'd5, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_CANCEL, 3'd5, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_TICK, 3'd7, 1'b1, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b1, 16'd0, 6'd63, KIND_LEVEL, 3'd0, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd5, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd3, 1'b0, 1'b1, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_TICK, 3'd4, 1'b1, 1'b0, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd3, 1'b0, 1'b0, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd3, 1'b1, 1'b0, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_CANCEL, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_TICK, 3'd1, 1'b0, 1'b0, 1'b0, 3'd0, EV_PRESS},
        '{1'b1, 16'hFFFF, 6'd0, KIND_LEVEL, 3'd1, 1'b0, 1'b1, 1'b1, 3'd1, EV_PRESS},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd1, 1'b1, 1'b1, 1'b1, 3'd1, EV_RELEASE},
        '{1'b0, 16'd0, 6'd0, KIND_LEVEL, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, EV_PRESS}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic               cfg_we;
    logic               cfg_index;
    logic [CNT_W-1:0]   cfg_data;

    phase_t             model_phase [BUTTON_COUNT];
    logic [CNT_W-1:0]   model_count [BUTTON_COUNT];
    logic [CNT_W-1:0]   model_ticks;
    logic [MASK_W-1:0]  model_mask;

    event_t             step_events [$];
    event_t             pending_events [$];
    int                 fail_count;
    int                 cycle_count;
    int                 ready_hold;
    int                 stall_draw;
    bit                 no_idle;
    event_t             got_ev;
    event_t             want_ev;

    multi_button_long_press_detector_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_button_long_press_detector_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic predict_events(input logic [KIND_W-1:0] kind, input logic [BTN_W-1:0] btn,
                                  input logic lvl);
        int i;
        logic [CNT_W-1:0] load;
        step_events.delete();
        if (kind == KIND_TICK) begin
            for (i = 0; i < BUTTON_COUNT; i++) begin
                if (model_phase[i] == PH_PRESSED && model_count[i] != '0) begin
                    model_count[i] = model_count[i] - 1'b1;
                    if (model_count[i] == '0) begin
                        model_phase[i] = PH_LONG;
                        step_events.push_back('{BTN_W'(i), EV_LONG_PRESS, 1'b0});
                    end
                end
            end
        end else if ((kind == KIND_LEVEL || kind == KIND_CANCEL) && int'(btn) < BUTTON_COUNT) begin
            if (kind == KIND_CANCEL) begin
                if (model_phase[btn] == PH_PRESSED || model_phase[btn] == PH_LONG) begin
                    model_phase[btn] = PH_IDLE;
                    model_count[btn] = '0;
                end
            end else if (!lvl) begin
                if (model_phase[btn] == PH_IDLE) begin
                    if (int'(btn) < MASK_W && model_mask[btn]) begin
                        load = (model_ticks == '0) ? CNT_W'(1) : model_ticks;
                        model_count[btn] = load;
                    end else begin
                        step_events.push_back('{btn, EV_PRESS, 1'b0});
                    end
                    model_phase[btn] = PH_PRESSED;
                end
            end else if (model_phase[btn] == PH_PRESSED || model_phase[btn] == PH_LONG) begin
                step_events.push_back('{btn, (model_phase[btn] == PH_PRESSED) ?
                                       EV_RELEASE : EV_LONG_RELEASE, 1'b0});
                model_count[btn] = '0;
                model_phase[btn] = PH_IDLE;
            end
        end
        if (step_events.size() > 0) begin
            step_events[step_events.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BTN_W-1:0] btn,
                             input logic lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, lvl, btn, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_and_predict(input logic [KIND_W-1:0] kind, input logic [BTN_W-1:0] btn,
                                    input logic lvl);
        send_item(kind, btn, lvl);
        predict_events(kind, btn, lvl);
        foreach (step_events[k]) pending_events.push_back(step_events[k]);
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CNT_W-1:0] ticks, input logic [MASK_W-1:0] mask);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TICKS;
        cfg_data <= ticks;
        @(posedge aclk);
        cfg_index <= CFG_MASK;
        cfg_data <= CNT_W'(mask);
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_ticks = ticks;
        model_mask = mask;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            got_ev = '{m_tdata[2:0], m_tdata[4:3], m_tlast};
            if (pending_events.size() == 0) begin
                $error("unexpected event: button %0d code %0d last %0d",
                       got_ev.button, got_ev.code, got_ev.last);
                fail_count++;
            end else begin
                want_ev = pending_events.pop_front();
                if (got_ev.button !== want_ev.button) begin
                    $error("event_button: expected %0d, got %0d", want_ev.button, got_ev.button);
                    fail_count++;
                end
                if (got_ev.code !== want_ev.code) begin
                    $error("event_code: expected %0d, got %0d", want_ev.code, got_ev.code);
                    fail_count++;
                end
                if (got_ev.last !== want_ev.last) begin
                    $error("last: expected %0d, got %0d", want_ev.last, got_ev.last);
                    fail_count++;
                end
            end
            stall_draw = no_idle ? 0 : $urandom_range(0, 5);
            ready_hold <= stall_draw;
            m_tready <= (stall_draw == 0);
        end else if (ready_hold > 1) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_hold <= 0;
            m_tready <= 1'b1;
        end
    end

    initial begin
        int p;
        int counted;
        int pick;
        logic [KIND_W-1:0] kind;
        logic [BTN_W-1:0] btn;
        logic lvl;
        logic [CNT_W-1:0] ticks;
        logic [MASK_W-1:0] mask;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_TICKS;
        cfg_data <= '0;
        no_idle = 1'b0;
        model_ticks = TICKS_RESET;
        model_mask = MASK_RESET;
        for (p = 0; p < BUTTON_COUNT; p++) begin
            model_phase[p] = PH_IDLE;
            model_count[p] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].cfg) begin
                s_tvalid <= 1'b0;
                wait_idle();
                write_config(DIRECTED[r].ticks, DIRECTED[r].mask);
            end
            send_item(DIRECTED[r].kind, DIRECTED[r].btn, DIRECTED[r].lvl);
            predict_events(DIRECTED[r].kind, DIRECTED[r].btn, DIRECTED[r].lvl);
            if (!DIRECTED[r].typed) begin
                foreach (step_events[k]) pending_events.push_back(step_events[k]);
            end else if (DIRECTED[r].has_ev) begin
                pending_events.push_back('{DIRECTED[r].ev_btn, DIRECTED[r].ev_code, 1'b1});
            end
        end
        s_tvalid <= 1'b0;

        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: ticks = CNT_W'(1);
                1: ticks = 16'hFFFF;
                default: ticks = CNT_W'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 4))
                0: mask = '0;
                1: mask = '1;
                default: mask = MASK_W'($urandom_range(0, 63));
            endcase
            write_config(ticks, mask);
            no_idle = (p == 2);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                lvl = 1'($urandom_range(0, 1));
                if (pick < 6) begin
                    kind = ($urandom_range(0, 1) == 0) ? KIND_UNUSED :
                           KIND_W'($urandom_range(0, 1));
                    btn = (kind == KIND_UNUSED) ? BTN_W'($urandom_range(0, 7)) :
                          BTN_W'($urandom_range(BUTTON_COUNT, 7));
                end else begin
                    counted++;
                    btn = BTN_W'($urandom_range(0, BUTTON_COUNT - 1));
                    if (pick < 40) begin
                        kind = KIND_TICK;
                        btn = BTN_W'($urandom_range(0, 7));
                    end else if (pick < 48) begin
                        kind = KIND_CANCEL;
                    end else begin
                        kind = KIND_LEVEL;
                        if ($urandom_range(0, 4) != 0) begin
                            lvl = (model_phase[btn] != PH_IDLE);
                        end
                    end
                end
                send_and_predict(kind, btn, lvl);
            end
            s_tvalid <= 1'b0;
        end
        no_idle = 1'b0;

        wait_idle();
        if (fail_count == 0) begin
            $display("multi_button_long_press_detector_unit_tb OK");
        end else begin
            $display("multi_button_long_press_detector_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
